### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("checker assertion failed");

// Same check with a short message naming a handshake rule.
`define ASSERT_HS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("handshake rule broken");

`endif

### rtl/core/tcc_pkg.sv
// Package with widths, types and helpers of the tetrahedron circumcenter unit.
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_BITS   = 40;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS + 2;
    localparam int LEN_W   = SQ_W;
    localparam int CROSS_W = SQ_W + 1;
    localparam int SPL_W   = (CROSS_W + 1) / 2;
    localparam int LH_W    = LEN_W - SPL_W;
    localparam int XH_W    = CROSS_W - SPL_W;
    localparam int MO_W    = SPL_W + 1;
    localparam int PR_W    = 2 * MO_W;
    localparam int TRI_W   = EDGE_W + CROSS_W + 2;
    localparam int DEN_W   = TRI_W + 1;
    localparam int TERM_W  = LEN_W + CROSS_W + 1;
    localparam int NUM_W   = TERM_W + 2;
    localparam int NP_W    = NUM_W + 1;
    localparam int QB      = OUT_BITS;
    localparam int CMP_W   = ((NP_W > DEN_W + QB) ? NP_W : DEN_W + QB) + 1;
    localparam int SUM_W   = OUT_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_BITS-1:0]   center_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [SQ_W-1:0]       sq_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic        [LEN_W-1:0]      len_t;
    typedef logic signed [PR_W-1:0]       prod_t;
    typedef logic signed [TRI_W-1:0]      tri_t;
    typedef logic signed [DEN_W-1:0]      den_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [NUM_W-1:0]      num_t;

    localparam center_t CENTER_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam center_t CENTER_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Operand pairs of the three cross products: ba x ca, da x ba, ca x da.
    localparam int CU [3] = '{0, 2, 1};
    localparam int CV [3] = '{1, 0, 2};
    // Component rotation of a cross product.
    localparam int J1 [3] = '{1, 2, 0};
    localparam int J2 [3] = '{2, 0, 1};

    function automatic prod_t smul(input logic signed [MO_W-1:0] x,
                                   input logic signed [MO_W-1:0] y);
        return x * y;
    endfunction

endpackage

### rtl/core/tet_circumcenter.sv
// Top level of the pipelined tetrahedron circumcenter unit.
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; a new word enters while older ones are in flight.
// The pipeline has seven arithmetic stages, 40 divider stages and the output register.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
module tet_circumcenter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcc_pkg::coord_t  a_x,
    input  tcc_pkg::coord_t  a_y,
    input  tcc_pkg::coord_t  a_z,
    input  tcc_pkg::coord_t  b_x,
    input  tcc_pkg::coord_t  b_y,
    input  tcc_pkg::coord_t  b_z,
    input  tcc_pkg::coord_t  c_x,
    input  tcc_pkg::coord_t  c_y,
    input  tcc_pkg::coord_t  c_z,
    input  tcc_pkg::coord_t  d_x,
    input  tcc_pkg::coord_t  d_y,
    input  tcc_pkg::coord_t  d_z,
    output logic             out_valid,
    input  logic             out_ready,
    output tcc_pkg::center_t center_x,
    output tcc_pkg::center_t center_y,
    output tcc_pkg::center_t center_z,
    output logic             degenerate
);
    import tcc_pkg::*;

    logic out_valid_reg;

    // The whole pipeline advances together whenever the output register
    // is empty or its word is being taken.
    logic adv;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    coord_t pin [4][3];
    assign pin[0][0] = a_x;
    assign pin[0][1] = a_y;
    assign pin[0][2] = a_z;
    assign pin[1][0] = b_x;
    assign pin[1][1] = b_y;
    assign pin[1][2] = b_z;
    assign pin[2][0] = c_x;
    assign pin[2][1] = c_y;
    assign pin[2][2] = c_z;
    assign pin[3][0] = d_x;
    assign pin[3][1] = d_y;
    assign pin[3][2] = d_z;

    // Valid bits of stages 1 to 6; stage 7 is slot 0 of the divider arrays.
    logic [6:1] v_reg;
    logic [6:1] v_next;

    // Stage 1: first corner and the edge vectors ba, ca, da.
    coord_t a1_reg [3];
    coord_t a1_next [3];
    edge_t  e1_reg [3][3];
    edge_t  e1_next [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a1_next[k] = pin[0][k];
            for (int e = 0; e < 3; e++)
            begin
                e1_next[e][k] = EDGE_W'(pin[e+1][k]) - EDGE_W'(pin[0][k]);
            end
        end
    end

    // Stage 2: the two products of each cross product component and the
    // squares of the edge components.
    coord_t a2_reg [3];
    edge_t  ba2_reg [3];
    sq_t    cp_reg [3][3][2];
    sq_t    cp_next [3][3][2];
    sq_t    sq_reg [3][3];
    sq_t    sq_next [3][3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cp_next[c][j][0] = SQ_W'(smul(MO_W'(e1_reg[CU[c]][J1[j]]),
                                              MO_W'(e1_reg[CV[c]][J2[j]])));
                cp_next[c][j][1] = SQ_W'(smul(MO_W'(e1_reg[CU[c]][J2[j]]),
                                              MO_W'(e1_reg[CV[c]][J1[j]])));
                sq_next[c][j]    = SQ_W'(smul(MO_W'(e1_reg[c][j]),
                                              MO_W'(e1_reg[c][j])));
            end
        end
    end

    // Stage 3: cross products and squared edge lengths.
    coord_t a3_reg [3];
    edge_t  ba3_reg [3];
    cross_t cr_reg [3][3];
    cross_t cr_next [3][3];
    len_t   len_reg [3];
    len_t   len_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cr_next[c][j] = CROSS_W'(cp_reg[c][j][0]) - CROSS_W'(cp_reg[c][j][1]);
            end
            len_next[c] = LEN_W'($unsigned(sq_reg[c][0])) + LEN_W'($unsigned(sq_reg[c][1]))
                        + LEN_W'($unsigned(sq_reg[c][2]));
        end
    end

    // Stage 4: partial products. Wide operands are cut into a low unsigned
    // half and a high half so that every multiplier stays narrow.
    coord_t a4_reg [3];
    prod_t  tp_reg [3][2];
    prod_t  tp_next [3][2];
    prod_t  np_reg [3][3][4];
    prod_t  np_next [3][3][4];

    always_comb
    begin
        logic signed [XH_W-1:0] xh;
        logic [SPL_W-1:0]       xl;
        logic [LH_W-1:0]        lh;
        logic [SPL_W-1:0]       ll;
        xh = '0;
        xl = '0;
        lh = '0;
        ll = '0;
        for (int j = 0; j < 3; j++)
        begin
            xh = cr_reg[2][j][CROSS_W-1:SPL_W];
            xl = cr_reg[2][j][SPL_W-1:0];
            tp_next[j][0] = smul(MO_W'(ba3_reg[j]), MO_W'(xh));
            tp_next[j][1] = smul(MO_W'(ba3_reg[j]), MO_W'(xl));
        end
        // Term t pairs cross product t with the squared length of the edge
        // that it leaves out.
        for (int k = 0; k < 3; k++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                xh = cr_reg[t][k][CROSS_W-1:SPL_W];
                xl = cr_reg[t][k][SPL_W-1:0];
                lh = len_reg[2-t][LEN_W-1:SPL_W];
                ll = len_reg[2-t][SPL_W-1:0];
                np_next[k][t][0] = smul(MO_W'(lh), MO_W'(xh));
                np_next[k][t][1] = smul(MO_W'(lh), MO_W'(xl));
                np_next[k][t][2] = smul(MO_W'(ll), MO_W'(xh));
                np_next[k][t][3] = smul(MO_W'(ll), MO_W'(xl));
            end
        end
    end

    // Stage 5: triple product and the nine weighted cross product terms.
    coord_t a5_reg [3];
    tri_t   tri_reg;
    tri_t   tri_next;
    term_t  term_reg [3][3];
    term_t  term_next [3][3];

    always_comb
    begin
        tri_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            tri_next = tri_next + (TRI_W'(tp_reg[j][0]) <<< SPL_W) + TRI_W'(tp_reg[j][1]);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                term_next[k][t] = (TERM_W'(np_reg[k][t][0]) <<< (2 * SPL_W))
                                + ((TERM_W'(np_reg[k][t][1]) + TERM_W'(np_reg[k][t][2]))
                                   <<< SPL_W)
                                + TERM_W'(np_reg[k][t][3]);
            end
        end
    end

    // Stage 6: numerators and the denominator, twice the triple product.
    coord_t a6_reg [3];
    num_t   num_reg [3];
    num_t   num_next [3];
    den_t   den_reg;
    den_t   den_next;

    always_comb
    begin
        den_next = DEN_W'(tri_reg) <<< 1;
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = NUM_W'(term_reg[k][0]) + NUM_W'(term_reg[k][1])
                        + NUM_W'(term_reg[k][2]);
        end
    end

    // Divider slots. Slot 0 is stage 7: magnitudes, with half the divisor
    // added to the dividend for round-half-away-from-zero. Slot s retires
    // quotient bit QB-s; slot 1 also flags a quotient of 2^QB or more,
    // which saturates the output unless the divisor is zero.
    logic                 dv_reg   [QB+1];
    logic [NP_W-1:0]      drem_reg [QB+1][3];
    logic [NP_W-1:0]      drem_next[QB+1][3];
    logic [QB-1:0]        dquo_reg [QB+1][3];
    logic [QB-1:0]        dquo_next[QB+1][3];
    logic [2:0]           dneg_reg [QB+1];
    logic [2:0]           dovf_reg [QB+1];
    logic [2:0]           dovf_next[QB+1];
    logic [DEN_W-1:0]     dad_reg  [QB+1];
    logic                 ddeg_reg [QB+1];
    coord_t               da_reg   [QB+1][3];

    logic [DEN_W-1:0] ad0;
    logic [2:0]       neg0;

    always_comb
    begin
        logic [NUM_W-1:0] an;
        an  = '0;
        ad0 = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        for (int k = 0; k < 3; k++)
        begin
            an = num_reg[k][NUM_W-1] ? NUM_W'(-num_reg[k]) : NUM_W'(num_reg[k]);
            drem_next[0][k] = NP_W'(an) + NP_W'(ad0 >> 1);
            neg0[k]         = num_reg[k][NUM_W-1] ^ den_reg[DEN_W-1];
            dquo_next[0][k] = '0;
        end
        dovf_next[0] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dad_reg[0]  <= ad0;
            ddeg_reg[0] <= (den_reg == '0);
            dneg_reg[0] <= neg0;
            dovf_reg[0] <= dovf_next[0];
            for (int k = 0; k < 3; k++)
            begin
                drem_reg[0][k] <= drem_next[0][k];
                dquo_reg[0][k] <= dquo_next[0][k];
                da_reg[0][k]   <= a6_reg[k];
            end
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_div
        localparam int  BI      = QB - s;
        localparam logic OVF_AT = (s == 1);

        always_comb
        begin
            logic [CMP_W-1:0] sh;
            logic [CMP_W-1:0] rw;
            logic             ge;
            sh = CMP_W'(dad_reg[s-1]) << BI;
            rw = '0;
            ge = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                rw = CMP_W'(drem_reg[s-1][k]);
                ge = (rw >= sh);
                drem_next[s][k] = ge ? NP_W'(rw - sh) : drem_reg[s-1][k];
                dquo_next[s][k] = dquo_reg[s-1][k];
                dquo_next[s][k][BI] = ge;
                dovf_next[s][k] = dovf_reg[s-1][k]
                                | (OVF_AT & (rw >= (CMP_W'(dad_reg[s-1]) << QB)));
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dad_reg[s]  <= dad_reg[s-1];
                ddeg_reg[s] <= ddeg_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
                dovf_reg[s] <= dovf_next[s];
                for (int k = 0; k < 3; k++)
                begin
                    drem_reg[s][k] <= drem_next[s][k];
                    dquo_reg[s][k] <= dquo_next[s][k];
                    da_reg[s][k]   <= da_reg[s-1][k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
        end
    end

    // Output stage: apply the sign, add the first corner and saturate.
    // A flat tetrahedron gives a zero center and the degenerate flag.
    center_t cen_reg [3];
    center_t cen_next [3];
    logic    deg_reg;

    always_comb
    begin
        logic signed [QB:0]      qs;
        logic signed [SUM_W-1:0] sum;
        qs  = '0;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            qs  = dneg_reg[QB][k] ? -$signed({1'b0, dquo_reg[QB][k]})
                                  : $signed({1'b0, dquo_reg[QB][k]});
            sum = SUM_W'(da_reg[QB][k]) + SUM_W'(qs);
            if (ddeg_reg[QB])
            begin
                cen_next[k] = '0;
            end
            else if (dovf_reg[QB][k])
            begin
                cen_next[k] = dneg_reg[QB][k] ? CENTER_MIN : CENTER_MAX;
            end
            else if (!sum[SUM_W-1] && (|sum[SUM_W-2:OUT_BITS-1]))
            begin
                cen_next[k] = CENTER_MAX;
            end
            else if (sum[SUM_W-1] && !(&sum[SUM_W-2:OUT_BITS-1]))
            begin
                cen_next[k] = CENTER_MIN;
            end
            else
            begin
                cen_next[k] = OUT_BITS'(sum);
            end
        end
    end

    // Payload registers of stages 1 to 6 and the output.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a1_reg[k]  <= a1_next[k];
                a2_reg[k]  <= a1_reg[k];
                a3_reg[k]  <= a2_reg[k];
                a4_reg[k]  <= a3_reg[k];
                a5_reg[k]  <= a4_reg[k];
                a6_reg[k]  <= a5_reg[k];
                ba2_reg[k] <= e1_reg[0][k];
                ba3_reg[k] <= ba2_reg[k];
                len_reg[k] <= len_next[k];
                num_reg[k] <= num_next[k];
                cen_reg[k] <= cen_next[k];
                for (int j = 0; j < 3; j++)
                begin
                    e1_reg[k][j]    <= e1_next[k][j];
                    sq_reg[k][j]    <= sq_next[k][j];
                    cp_reg[k][j][0] <= cp_next[k][j][0];
                    cp_reg[k][j][1] <= cp_next[k][j][1];
                    cr_reg[k][j]    <= cr_next[k][j];
                    term_reg[k][j]  <= term_next[k][j];
                    for (int p = 0; p < 4; p++)
                    begin
                        np_reg[k][j][p] <= np_next[k][j][p];
                    end
                end
                tp_reg[k][0] <= tp_next[k][0];
                tp_reg[k][1] <= tp_next[k][1];
            end
            tri_reg <= tri_next;
            den_reg <= den_next;
            deg_reg <= ddeg_reg[QB];
        end
    end

    always_comb
    begin
        v_next[1] = in_valid;
        for (int i = 2; i <= 6; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            dv_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= v_next;
            dv_reg[0]     <= v_reg[6];
            out_valid_reg <= dv_reg[QB];
        end
    end

    assign out_valid  = out_valid_reg;
    assign center_x   = cen_reg[0];
    assign center_y   = cen_reg[1];
    assign center_z   = cen_reg[2];
    assign degenerate = deg_reg;

endmodule

### rtl/core/tcc_checker.sv
// Port-level checker for the circumcenter unit, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcc_props (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input tcc_pkg::center_t center_x,
    input tcc_pkg::center_t center_y,
    input tcc_pkg::center_t center_z,
    input logic             degenerate
);
    import tcc_pkg::*;

    logic                  out_stall;
    logic [3*OUT_BITS:0]   out_word;
    logic                  center_zero;

    assign out_stall   = out_valid && !out_ready;
    assign out_word    = {center_x, center_y, center_z, degenerate};
    assign center_zero = (center_x == '0) && (center_y == '0) && (center_z == '0);

    // A waiting output word holds still until it is taken.
    `ASSERT_HS(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word))

    // A flat tetrahedron reports a zero center.
    `ASSERT_CLKD(a_deg_zero, clk, rst_n, out_valid && degenerate |-> center_zero)

    // The input is never held off while the output side is free.
    `ASSERT_CLKD(a_no_bubble, clk, rst_n, !out_valid || out_ready |-> in_ready)

    // Back pressure on the input only comes from a stalled output word.
    `ASSERT_CLKD(a_stall_src, clk, rst_n, !in_ready |-> out_stall)

endmodule

bind tet_circumcenter tcc_props u_tcc_checker (.*);
